>>> hdl/lhbp_pkg.sv
// lhbp_pkg: shared sizes, types, state encoding and counter update for the
// local history branch predictor. No dependencies.
`default_nettype none

package lhbp_pkg;

    localparam int PC_INDEX_BITS = 10;
    localparam int HISTORY_BITS  = 10;
    localparam int PC_WIDTH      = 32;

    localparam int BHT_DEPTH = 1 << PC_INDEX_BITS;
    localparam int PCT_DEPTH = 1 << HISTORY_BITS;

    // clear sweep covers the deeper of the two tables
    localparam int CLR_BITS = (PC_INDEX_BITS > HISTORY_BITS) ? PC_INDEX_BITS : HISTORY_BITS;

    localparam int CTR_BITS = 2;

    typedef logic [PC_INDEX_BITS-1:0] t_bidx;
    typedef logic [HISTORY_BITS-1:0]  t_hist;
    typedef logic [CTR_BITS-1:0]      t_ctr;
    typedef logic [CLR_BITS-1:0]      t_clr;

    localparam t_ctr CTR_MIN = 2'd0;
    localparam t_ctr CTR_MAX = 2'd3;

    typedef enum logic {
        ACT_PREDICT = 1'b0,
        ACT_TRAIN   = 1'b1
    } t_action;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_HIST,
        S_CTR
    } t_state;

    // 2-bit saturating counter step
    function automatic t_ctr counter_next(input t_ctr ctr, input logic taken);
        t_ctr res;
        if (taken) begin
            res = (ctr == CTR_MAX) ? CTR_MAX : ctr + t_ctr'(1);
        end else begin
            res = (ctr == CTR_MIN) ? CTR_MIN : ctr - t_ctr'(1);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

>>> hdl/local_history_branch_predictor.sv
// local_history_branch_predictor: two-level local history predictor top level.
// Depends on lhbp_pkg and lhbp_ram.
`default_nettype none

// Usage
//   input channel: i_valid / o_stall carry one word of i_action, i_pc and
//   i_outcome. a word is taken at a rising edge with i_valid high and o_stall low.
//   output channel: o_valid / i_stall carry o_prediction, one word for each
//   predict word; train words give no output word.
//   each word passes through a read of the history table, a read of the
//   pattern table and a final step that writes both back (train) or loads the
//   output register (predict). the two memory reads are dependent and
//   registered; a new word is taken once the previous one has finished.
//   a prediction shows on o_valid from the output register loaded in the final step.
//   after reset a clearing pass writes zero to every entry of both tables,
//   one entry a cycle, as a counter of max(PC_INDEX_BITS, HISTORY_BITS) bits
//   runs through all its values; o_stall is high until it ends.
//   the output register holds a prediction while i_stall is high; the next
//   word is still taken meanwhile, and a following predict word waits in its
//   last cycle until the output register is free.
module local_history_branch_predictor (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    output logic                                 o_stall,
    input  wire logic                            i_action,
    input  wire logic [lhbp_pkg::PC_WIDTH-1:0]   i_pc,
    input  wire logic                            i_outcome,
    output logic                                 o_valid,
    input  wire logic                            i_stall,
    output logic                                 o_prediction
);

    // control state
    lhbp_pkg::t_state r_state, n_state;
    lhbp_pkg::t_clr   r_clr_cnt;
    logic             r_out_valid;

    // payload of the word in flight
    lhbp_pkg::t_bidx  r_bi;
    logic             r_action;
    logic             r_outcome;
    lhbp_pkg::t_hist  r_hist;
    logic             r_pred;

    // memory ports
    logic                   bht_we, bht_re;
    lhbp_pkg::t_bidx        bht_waddr;
    lhbp_pkg::t_hist        bht_wdata, bht_rdata;
    logic                   pct_we, pct_re;
    lhbp_pkg::t_hist        pct_waddr, pct_raddr;
    lhbp_pkg::t_ctr         pct_wdata, pct_rdata;

    logic                   accept;
    logic                   out_load;
    logic                   ctr_hold;
    logic [lhbp_pkg::HISTORY_BITS:0] hist_shift;

    assign accept = i_valid && !o_stall;
    // a predict word cannot finish while the output register is full and i_stall is high
    assign ctr_hold = (r_action == lhbp_pkg::ACT_PREDICT) && r_out_valid && i_stall;
    // newest outcome enters at the bottom, the oldest bit falls off the top
    assign hist_shift = {r_hist, r_outcome};

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            lhbp_pkg::S_CLEAR: begin
                if (&r_clr_cnt) begin
                    n_state = lhbp_pkg::S_IDLE;
                end
            end
            lhbp_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_state = lhbp_pkg::S_HIST;
                end
            end
            lhbp_pkg::S_HIST: begin
                n_state = lhbp_pkg::S_CTR;
            end
            lhbp_pkg::S_CTR: begin
                if (!ctr_hold) begin
                    n_state = lhbp_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = lhbp_pkg::S_CLEAR;
            end
        endcase
    end

    // outputs and memory controls
    always_comb begin
        o_stall   = 1'b1;
        bht_re    = 1'b0;
        bht_we    = 1'b0;
        bht_waddr = r_bi;
        bht_wdata = hist_shift[lhbp_pkg::HISTORY_BITS-1:0];
        pct_re    = 1'b0;
        pct_raddr = bht_rdata;
        pct_we    = 1'b0;
        pct_waddr = r_hist;
        pct_wdata = lhbp_pkg::counter_next(pct_rdata, r_outcome);
        out_load  = 1'b0;
        case (r_state)
            lhbp_pkg::S_CLEAR: begin
                bht_we    = 1'b1;
                bht_waddr = r_clr_cnt[lhbp_pkg::PC_INDEX_BITS-1:0];
                bht_wdata = '0;
                pct_we    = 1'b1;
                pct_waddr = r_clr_cnt[lhbp_pkg::HISTORY_BITS-1:0];
                pct_wdata = lhbp_pkg::CTR_MIN;
            end
            lhbp_pkg::S_IDLE: begin
                o_stall = 1'b0;
                bht_re  = i_valid;
            end
            lhbp_pkg::S_HIST: begin
                pct_re = 1'b1;
            end
            lhbp_pkg::S_CTR: begin
                if (r_action == lhbp_pkg::ACT_TRAIN) begin
                    bht_we = 1'b1;
                    pct_we = 1'b1;
                end else begin
                    out_load = !ctr_hold;
                end
            end
            default: begin
                o_stall = 1'b1;
            end
        endcase
    end

    lhbp_ram #(
        .WIDTH (lhbp_pkg::HISTORY_BITS),
        .DEPTH (lhbp_pkg::BHT_DEPTH)
    ) u_bht (
        .i_clk   (i_clk),
        .i_we    (bht_we),
        .i_waddr (bht_waddr),
        .i_wdata (bht_wdata),
        .i_re    (bht_re),
        .i_raddr (i_pc[lhbp_pkg::PC_INDEX_BITS-1:0]),
        .o_rdata (bht_rdata)
    );

    lhbp_ram #(
        .WIDTH (lhbp_pkg::CTR_BITS),
        .DEPTH (lhbp_pkg::PCT_DEPTH)
    ) u_pct (
        .i_clk   (i_clk),
        .i_we    (pct_we),
        .i_waddr (pct_waddr),
        .i_wdata (pct_wdata),
        .i_re    (pct_re),
        .i_raddr (pct_raddr),
        .o_rdata (pct_rdata)
    );

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lhbp_pkg::S_CLEAR;
            r_clr_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == lhbp_pkg::S_CLEAR) begin
                r_clr_cnt <= r_clr_cnt + lhbp_pkg::t_clr'(1);
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_bi      <= i_pc[lhbp_pkg::PC_INDEX_BITS-1:0];
            r_action  <= i_action;
            r_outcome <= i_outcome;
        end
        if (r_state == lhbp_pkg::S_HIST) begin
            r_hist <= bht_rdata;
        end
        // taken when counter is weakly or strongly taken
        if (out_load) begin
            r_pred <= pct_rdata[lhbp_pkg::CTR_BITS-1];
        end
    end

    assign o_valid      = r_out_valid;
    assign o_prediction = r_pred;

endmodule

`default_nettype wire

>>> hdl/lhbp_ram.sv
// lhbp_ram: generic single write port, single read port memory with a
// registered read. No dependencies.
`default_nettype none

module lhbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // read data holds while no read is issued
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

>>> verif/tb_local_history_branch_predictor.sv
// tb_local_history_branch_predictor: self-checking testbench for the local history
// branch predictor. Depends on lhbp_pkg and the local_history_branch_predictor RTL.
module tb_local_history_branch_predictor;

    timeunit 1ns;
    timeprecision 1ps;

    // no typed-in expectation for this table row, the shadow predictor decides
    localparam int NO_TYPED = -1;
    localparam int N_DIRECTED = 24;
    localparam int N_RANDOM = 1000;
    localparam int N_LOOPS = 8;
    localparam logic [31:0] LOW_MASK = (32'd1 << lhbp_pkg::PC_INDEX_BITS) - 32'd1;

    // clock, reset and dut ports
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic        i_action = 1'b0;
    logic [31:0] i_pc = 32'd0;
    logic        i_outcome = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic        o_prediction;

    // shadow copy of both predictor tables, cleared like the dut after reset
    lhbp_pkg::t_hist hist_shadow [lhbp_pkg::BHT_DEPTH] = '{default: '0};
    lhbp_pkg::t_ctr  ctr_shadow  [lhbp_pkg::PCT_DEPTH] = '{default: '0};

    // predicted directions still waiting to come out of the dut, oldest first
    logic  direction_q [$];

    int errors = 0;
    int n_predict = 0;
    int n_train = 0;
    int n_checked = 0;
    bit gapless = 1'b0;

    typedef struct packed {
        lhbp_pkg::t_action act;
        logic [31:0]       pc;
        logic              outcome;
        int                typed;
    } t_dir_row;

    // directed stimulus: reset state, counter bounds, pc aliasing, history fill
    t_dir_row dir_rows [N_DIRECTED] = '{
        '{lhbp_pkg::ACT_PREDICT, 32'h0000_0000, 1'b0, 0},        // cleared tables: not taken
        '{lhbp_pkg::ACT_PREDICT, 32'hFFFF_FFFF, 1'b0, 0},        // all-ones pc, still not taken
        '{lhbp_pkg::ACT_TRAIN,   32'h0000_0000, 1'b0, NO_TYPED}, // not taken at the floor
        '{lhbp_pkg::ACT_PREDICT, 32'h0000_0000, 1'b0, 0},        // floor held at strongly not taken
        '{lhbp_pkg::ACT_TRAIN,   32'h0000_0001, 1'b1, NO_TYPED},
        '{lhbp_pkg::ACT_TRAIN,   32'h0000_0002, 1'b1, NO_TYPED},
        '{lhbp_pkg::ACT_PREDICT, 32'h0000_0003, 1'b0, NO_TYPED}, // shared counter weakly taken
        '{lhbp_pkg::ACT_TRAIN,   32'h0000_0003, 1'b1, NO_TYPED},
        '{lhbp_pkg::ACT_TRAIN,   32'h0000_0004, 1'b1, NO_TYPED}, // taken at the ceiling
        '{lhbp_pkg::ACT_TRAIN,   32'h0000_0005, 1'b0, NO_TYPED},
        '{lhbp_pkg::ACT_PREDICT, 32'h0000_0006, 1'b0, NO_TYPED},
        '{lhbp_pkg::ACT_TRAIN,   32'h0000_0006, 1'b0, NO_TYPED},
        '{lhbp_pkg::ACT_PREDICT, 32'h0000_0007, 1'b0, NO_TYPED},
        '{lhbp_pkg::ACT_TRAIN,   32'hFFFF_FC01, 1'b1, NO_TYPED}, // aliases pc 1 via high bits
        '{lhbp_pkg::ACT_PREDICT, 32'h0000_0401, 1'b0, NO_TYPED},
        '{lhbp_pkg::ACT_PREDICT, 32'h8000_0001, 1'b1, NO_TYPED}, // outcome ignored on predict
        '{lhbp_pkg::ACT_TRAIN,   32'h0000_03FF, 1'b1, NO_TYPED}, // shift outcomes into one history
        '{lhbp_pkg::ACT_TRAIN,   32'h0000_03FF, 1'b1, NO_TYPED},
        '{lhbp_pkg::ACT_TRAIN,   32'h0000_03FF, 1'b1, NO_TYPED},
        '{lhbp_pkg::ACT_TRAIN,   32'h0000_03FF, 1'b1, NO_TYPED},
        '{lhbp_pkg::ACT_TRAIN,   32'h0000_03FF, 1'b0, NO_TYPED},
        '{lhbp_pkg::ACT_TRAIN,   32'h0000_03FF, 1'b1, NO_TYPED},
        '{lhbp_pkg::ACT_TRAIN,   32'h0000_03FF, 1'b1, NO_TYPED},
        '{lhbp_pkg::ACT_PREDICT, 32'hABCD_E3FF, 1'b0, NO_TYPED}
    };

    local_history_branch_predictor u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_action     (i_action),
        .i_pc         (i_pc),
        .i_outcome    (i_outcome),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_prediction (o_prediction)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // shadow predictor: returns the direction the tables give for this branch,
    // and on a train word moves the counter and shifts the outcome into history
    function automatic logic branch_lookup_update(input lhbp_pkg::t_action act,
                                                  input logic [31:0] pc,
                                                  input logic outcome);
        lhbp_pkg::t_bidx bidx;
        lhbp_pkg::t_hist hist;
        lhbp_pkg::t_ctr  ctr;
        logic            taken;
        bidx  = lhbp_pkg::t_bidx'(pc);
        hist  = hist_shadow[bidx];
        ctr   = ctr_shadow[hist];
        taken = (ctr >= 2'd2);
        if (act == lhbp_pkg::ACT_TRAIN) begin
            if (outcome) begin
                if (ctr != lhbp_pkg::CTR_MAX) ctr = ctr + 2'd1;
            end else begin
                if (ctr != lhbp_pkg::CTR_MIN) ctr = ctr - 2'd1;
            end
            ctr_shadow[hist]  = ctr;
            // oldest bit falls off the top
            hist_shadow[bidx] = lhbp_pkg::t_hist'({hist, outcome});
        end
        return taken;
    endfunction

    // input gap: mostly none or short, now and then long, none at all in bursts
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (gapless || r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // drive one word, hold it until the dut takes it, then log the expectation
    task automatic send_word(input lhbp_pkg::t_action act, input logic [31:0] pc,
                             input logic outcome, input int typed);
        int   gap;
        logic taken;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_action  <= act;
        i_pc      <= pc;
        i_outcome <= outcome;
        @(posedge i_clk);
        while (o_stall !== 1'b0) @(posedge i_clk);
        // word taken at this edge
        taken = branch_lookup_update(act, pc, outcome);
        if (act == lhbp_pkg::ACT_PREDICT) begin
            direction_q.push_back((typed == NO_TYPED) ? taken : typed[0]);
            n_predict++;
        end else begin
            n_train++;
        end
    endtask

    // output stall: open stretches of varying length, short holds, a few long ones
    initial begin : stall_gen
        int open_len;
        int hold_len;
        forever begin
            open_len = ($urandom_range(0, 99) < 10) ? $urandom_range(50, 200)
                                                    : $urandom_range(1, 6);
            repeat (open_len) @(posedge i_clk);
            i_stall <= 1'b1;
            hold_len = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60)
                                                   : $urandom_range(1, 3);
            repeat (hold_len) @(posedge i_clk);
            i_stall <= 1'b0;
        end
    end

    // check every prediction the dut hands over against the oldest expectation
    always @(posedge i_clk) begin
        logic want;
        if (i_rst_n && o_valid === 1'b1 && i_stall === 1'b0) begin
            if (direction_q.size() == 0) begin
                $display("%0t unexpected prediction word: expected none, actual %b",
                         $time, o_prediction);
                errors++;
            end else begin
                want = direction_q.pop_front();
                n_checked++;
                if (o_prediction !== want) begin
                    $display("%0t prediction mismatch: expected %b, actual %b",
                             $time, want, o_prediction);
                    errors++;
                end
            end
        end
    end

    // stimulus and end of run
    initial begin : main_seq
        logic [31:0] loop_pc     [N_LOOPS];
        logic [15:0] loop_bits   [N_LOOPS];
        int          loop_period [N_LOOPS];
        int          loop_pos    [N_LOOPS];
        int          sent;
        int          k;
        logic [31:0] pc;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table, o_stall covers the clearing pass
        for (int r = 0; r < N_DIRECTED; r++) begin
            send_word(dir_rows[r].act, dir_rows[r].pc, dir_rows[r].outcome, dir_rows[r].typed);
        end

        // a handful of loop branches, each with a repeating outcome pattern
        for (int j = 0; j < N_LOOPS; j++) begin
            loop_pc[j]     = $urandom;
            loop_bits[j]   = 16'($urandom);
            loop_period[j] = $urandom_range(1, 14);
            loop_pos[j]    = 0;
        end

        sent = 0;
        while (sent < N_RANDOM) begin
            if (sent % 50 == 0) gapless = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 99) < 75) begin
                // well-formed: usually look up a loop branch, then train it with its pattern;
                // high pc bits vary so aliases land on the same history
                k = $urandom_range(0, N_LOOPS - 1);
                pc = ($urandom & ~LOW_MASK) | (loop_pc[k] & LOW_MASK);
                if ($urandom_range(0, 3) != 0) begin
                    send_word(lhbp_pkg::ACT_PREDICT, pc, 1'($urandom), NO_TYPED);
                    sent++;
                end
                send_word(lhbp_pkg::ACT_TRAIN, pc, loop_bits[k][loop_pos[k]], NO_TYPED);
                sent++;
                loop_pos[k] = (loop_pos[k] + 1) % loop_period[k];
                // occasionally swap in a fresh branch
                if ($urandom_range(0, 99) < 2) begin
                    loop_pc[k]     = $urandom;
                    loop_bits[k]   = 16'($urandom);
                    loop_period[k] = $urandom_range(1, 14);
                    loop_pos[k]    = 0;
                end
            end else begin
                // noise: any branch, any action
                send_word(lhbp_pkg::t_action'($urandom_range(0, 1)), $urandom, 1'($urandom),
                          NO_TYPED);
                sent++;
            end
        end

        i_valid <= 1'b0;
        while (direction_q.size() != 0) @(posedge i_clk);
        // the last prediction has left, allow some slack
        repeat (10) @(posedge i_clk);

        $display("covered %0d predict and %0d train words, %0d predictions checked",
                 n_predict, n_train, n_checked);
        $display("mismatches and unexpected words: %0d", errors);
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin : watchdog
        #10_000_000;
        $display("%0t timeout, %0d predictions still outstanding", $time, direction_q.size());
        $display("Regression FAIL");
        $finish;
    end

endmodule
